// ===== design/utf8s_pkg.sv =====
// shared types and constants for the utf-8 sanitizer
`timescale 1ns / 1ps
package utf8s_pkg;

	localparam int unsigned MAX_OUT = 6;
	localparam int unsigned CNT_W = 3;

	localparam logic [7:0] BYTE_C2 = 8'hC2;
	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] LEAD_LO = 8'hC0;
	localparam logic [7:0] LEAD_MIN = 8'hC2;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] LEAD_MAX = 8'hF4;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] CONT_90 = 8'h90;
	localparam logic [7:0] CONT_A0 = 8'hA0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_blob;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

	// bytes produced by one request, emitted in index order
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    end_of_blob;
	} job_t;

endpackage

// ===== design/utf8_sanitize_latin1_repair_top.sv =====
// top level of the utf-8 sanitizer with latin-1 repair
// usage:
//   in channel (in_valid/in_ready/in_data) takes one raw byte per request,
//   with end_of_blob set on the final byte of a blob.
//   out channel (out_valid/out_ready/out_data) gives well-formed utf-8 bytes,
//   one per request; run_last marks the last byte caused by an input byte,
//   stream_end the last one of the blob. a final byte that yields nothing
//   gives one empty end marker (has_byte 0).
// path: the first result of a request passes the job queue and then the output
//   register before it is valid, given an idle output.
// throughput: the front end takes one byte per cycle while the job queue has
//   room; the serializer sends one output byte per cycle unless out_ready
//   holds it. the serializer's single output byte per cycle sets the rate.
// stalls: when out_ready is low the output register holds, the queue
//   (QUEUE_DEPTH jobs) fills and in_ready then drops.
// reset: arst_n clears the pending sequence, the queue and the output valid.
`timescale 1ns / 1ps
module utf8_sanitize_latin1_repair_top
	import utf8s_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic job_valid;
	job_t job;
	logic full;
	logic empty;
	logic pop;
	job_t head;

	utf8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_ready (!full),
		.job       (job)
	);

	utf8s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid && !full),
		.push_job (job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	utf8s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job       (head),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== design/utf8s_front.sv =====
// front end: holds the pending sequence and classifies requests into output jobs
`timescale 1ns / 1ps
module utf8s_front
	import utf8s_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);

	logic [7:0]      lead_q;
	logic [1:0]      hc_q;
	logic [2:0]      len_q;
	logic [1:0][7:0] cont_q;

	logic [7:0]              b;
	logic                    ok;
	logic [MAX_OUT-1:0][7:0] res;
	logic [CNT_W-1:0]        n;
	logic [7:0]              nlead;
	logic [1:0]              nhc;
	logic [2:0]              nlen;
	logic [1:0][7:0]         cont_n;
	logic                    accept;

	always_comb begin
		b = in_data.in_byte;
		ok = (b >= CONT_LO) && (b < LEAD_LO);
		if (hc_q == 2'd0) begin
			if (lead_q == LEAD_3 && b < CONT_A0) ok = 1'b0;
			if (lead_q == LEAD_ED && b >= CONT_A0) ok = 1'b0;
			if (lead_q == LEAD_4 && b < CONT_90) ok = 1'b0;
			if (lead_q == LEAD_MAX && b >= CONT_90) ok = 1'b0;
		end

		res = '0;
		n = '0;
		nlead = lead_q;
		nhc = hc_q;
		nlen = len_q;
		cont_n = cont_q;

		if (len_q != 3'd0 && ok) begin
			if ({1'b0, hc_q} + 3'd2 >= len_q) begin
				// sequence complete: pass it through unchanged
				res[n] = lead_q;
				n = n + 3'd1;
				if (hc_q >= 2'd1) begin
					res[n] = cont_q[0];
					n = n + 3'd1;
				end
				if (hc_q >= 2'd2) begin
					res[n] = cont_q[1];
					n = n + 3'd1;
				end
				res[n] = b;
				n = n + 3'd1;
				nlead = '0;
				nhc = '0;
				nlen = '0;
			end else begin
				cont_n[hc_q[0]] = b;
				nhc = hc_q + 2'd1;
			end
		end else begin
			// no sequence or a broken one: held continuations become latin-1 pairs
			if (len_q != 3'd0) begin
				if (hc_q >= 2'd1) begin
					res[n] = BYTE_C2;
					n = n + 3'd1;
					res[n] = cont_q[0];
					n = n + 3'd1;
				end
				if (hc_q >= 2'd2) begin
					res[n] = BYTE_C2;
					n = n + 3'd1;
					res[n] = cont_q[1];
					n = n + 3'd1;
				end
			end
			nlead = '0;
			nhc = '0;
			nlen = '0;
			// scan the byte as a fresh start
			if (b < CONT_LO) begin
				res[n] = b;
				n = n + 3'd1;
			end else if (b < LEAD_LO) begin
				res[n] = BYTE_C2;
				n = n + 3'd1;
				res[n] = b;
				n = n + 3'd1;
			end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
				nlead = b;
				nlen = (b < LEAD_3) ? 3'd2 : ((b < LEAD_4) ? 3'd3 : 3'd4);
			end
		end

		// end of blob flushes whatever is still pending
		if (in_data.end_of_blob) begin
			if (nlen != 3'd0) begin
				if (nhc >= 2'd1) begin
					res[n] = BYTE_C2;
					n = n + 3'd1;
					res[n] = cont_n[0];
					n = n + 3'd1;
				end
				if (nhc >= 2'd2) begin
					res[n] = BYTE_C2;
					n = n + 3'd1;
					res[n] = cont_n[1];
					n = n + 3'd1;
				end
			end
			nlead = '0;
			nhc = '0;
			nlen = '0;
		end
	end

	assign in_ready = job_ready;
	assign accept = in_valid && in_ready;

	// a request with no bytes and no end mark leaves no job
	assign job_valid = in_valid && ((n != '0) || in_data.end_of_blob);
	assign job.bytes = res;
	assign job.count = n;
	assign job.end_of_blob = in_data.end_of_blob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			hc_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			lead_q <= nlead;
			hc_q <= nhc;
			len_q <= nlen;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cont_q <= cont_n;
		end
	end

endmodule

// ===== design/utf8s_queue.sv =====
// short job queue between the front end and the serializer
`timescale 1ns / 1ps
module utf8s_queue
	import utf8s_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

	job_t              slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] cnt_q;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== design/utf8s_back.sv =====
// back end: walks the head job one byte per cycle into the output register unless the output is stalled
`timescale 1ns / 1ps
module utf8s_back
	import utf8s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic      load;
	logic      last;
	out_item_t nxt;

	assign load = job_valid && (!out_valid_q || out_ready);
	// a job with no bytes is the empty end marker
	assign last = (job.count == '0) || (idx_q == job.count - CNT_W'(1));
	assign job_pop = load && last;

	always_comb begin
		nxt.out_byte = (job.count == '0) ? 8'h00 : job.bytes[idx_q];
		nxt.has_byte = (job.count != '0);
		nxt.run_last = last;
		nxt.stream_end = last && job.end_of_blob;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? '0 : idx_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== design/utf8s_checker.sv =====
// port-level checks for the sanitizer, bound to the top level
`timescale 1ns / 1ps
module utf8s_checker
	import utf8s_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// empty marker only closes a blob
	a_marker_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_byte |-> out_data.run_last && out_data.stream_end)
		else $error("empty marker without end flags");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.has_byte |-> out_data.out_byte == 8'h00)
		else $error("empty marker carries a byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stream_end |-> out_data.run_last)
		else $error("stream end not on last result");

endmodule

bind utf8_sanitize_latin1_repair_top utf8s_checker u_chk (.*);

// ===== tb/tb.sv =====
// testbench for the utf-8 sanitizer: predicts the repaired byte stream and checks it
`timescale 1ns / 1ps
module tb;
	import utf8s_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 440;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_AFTER = 200;
	localparam int unsigned HOLD_CYCLES = 160;
	localparam int unsigned DRAIN_CYCLES = 20;

	class utf8_scoreboard;
		out_item_t expected_q[$];
		out_item_t step_q[$];
		logic [7:0] lead;
		logic [7:0] conts[2];
		int unsigned held;
		int unsigned seq_len;
		int unsigned mismatches, requests, results, blobs, repairs, markers;

		function new();
			lead = '0;
			conts[0] = '0;
			conts[1] = '0;
			held = 0;
			seq_len = 0;
			mismatches = 0;
			requests = 0;
			results = 0;
			blobs = 0;
			repairs = 0;
			markers = 0;
		endfunction

		function void emit(logic [7:0] b);
			out_item_t r;
			r.out_byte = b;
			r.has_byte = 1'b1;
			r.run_last = 1'b0;
			r.stream_end = 1'b0;
			step_q.push_back(r);
		endfunction

		// latin-1 reading of a lone continuation byte
		function void repair(logic [7:0] b);
			emit(BYTE_C2);
			emit(b);
			repairs++;
		endfunction

		function void drop_pending();
			for (int i = 0; i < held && i < 2; i++)
				repair(conts[i]);
			held = 0;
			seq_len = 0;
			lead = '0;
		endfunction

		function void scan_fresh(logic [7:0] b);
			if (b < CONT_LO) begin
				emit(b);
			end else if (b < LEAD_LO) begin
				repair(b);
			end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
				lead = b;
				held = 0;
				seq_len = (b < LEAD_3) ? 2 : ((b < LEAD_4) ? 3 : 4);
			end
		endfunction

		function void note_request(in_item_t it);
			logic [7:0] b;
			bit fits;
			b = it.in_byte;
			step_q.delete();
			requests++;
			if (it.end_of_blob)
				blobs++;
			if (seq_len != 0) begin
				fits = (b >= CONT_LO) && (b < LEAD_LO);
				// tighter range on the byte right after the lead
				if (held == 0) begin
					if (lead == LEAD_3 && b < CONT_A0)
						fits = 1'b0;
					if (lead == LEAD_ED && b >= CONT_A0)
						fits = 1'b0;
					if (lead == LEAD_4 && b < CONT_90)
						fits = 1'b0;
					if (lead == LEAD_MAX && b >= CONT_90)
						fits = 1'b0;
				end
				if (fits) begin
					if (held + 2 >= seq_len) begin
						emit(lead);
						for (int i = 0; i < held && i < 2; i++)
							emit(conts[i]);
						emit(b);
						held = 0;
						seq_len = 0;
						lead = '0;
					end else begin
						conts[held & 1] = b;
						held++;
					end
				end else begin
					drop_pending();
					scan_fresh(b);
				end
			end else begin
				scan_fresh(b);
			end
			if (it.end_of_blob) begin
				if (seq_len != 0)
					drop_pending();
				if (step_q.size() == 0) begin
					step_q.push_back(out_item_t'('0));
					markers++;
				end
			end
			if (step_q.size() != 0) begin
				step_q[step_q.size() - 1].run_last = 1'b1;
				step_q[step_q.size() - 1].stream_end = it.end_of_blob;
			end
			foreach (step_q[i])
				expected_q.push_back(step_q[i]);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: byte %h has_byte %b run_last %b stream_end %b",
						results, got.out_byte, got.has_byte, got.run_last, got.stream_end);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
					got.run_last !== want.run_last || got.stream_end !== want.stream_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at result %0d: expected %h/%b/%b/%b, got %h/%b/%b/%b",
						results, want.out_byte, want.has_byte, want.run_last, want.stream_end,
						got.out_byte, got.has_byte, got.run_last, got.stream_end);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	utf8_scoreboard sb;
	in_item_t stim_q[$];
	int unsigned items_sent = 0;
	int unsigned idle_cycles;

	utf8_sanitize_latin1_repair_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void add(logic [7:0] b);
		in_item_t it;
		it.in_byte = b;
		it.end_of_blob = 1'b0;
		stim_q.push_back(it);
	endfunction

	function void mark_end();
		stim_q[stim_q.size() - 1].end_of_blob = 1'b1;
	endfunction

	function logic [7:0] any_cont();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// legal byte after a lead, honoring the overlong, surrogate and range limits
	function logic [7:0] second_for(logic [7:0] ld);
		case (ld)
			LEAD_3: return 8'($urandom_range(8'hA0, 8'hBF));
			LEAD_ED: return 8'($urandom_range(8'h80, 8'h9F));
			LEAD_4: return 8'($urandom_range(8'h90, 8'hBF));
			LEAD_MAX: return 8'($urandom_range(8'h80, 8'h8F));
			default: return any_cont();
		endcase
	endfunction

	function void add_char();
		int unsigned pick, need, k;
		logic [7:0] ld;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			add(8'($urandom_range(0, 127)));
		end else if (pick < 48) begin
			add(8'($urandom_range(8'hC2, 8'hDF)));
			add(any_cont());
		end else if (pick < 63) begin
			ld = 8'($urandom_range(8'hE0, 8'hEF));
			add(ld);
			add(second_for(ld));
			add(any_cont());
		end else if (pick < 76) begin
			ld = 8'($urandom_range(8'hF0, 8'hF4));
			add(ld);
			add(second_for(ld));
			add(any_cont());
			add(any_cont());
		end else if (pick < 84) begin
			add(any_cont());
		end else if (pick < 89) begin
			add(pick < 86 ? 8'($urandom_range(8'hC0, 8'hC1)) : 8'($urandom_range(8'hF5, 8'hFF)));
		end else if (pick < 95) begin
			// truncated sequence
			ld = 8'($urandom_range(8'hC2, 8'hF4));
			need = (ld < LEAD_3) ? 1 : ((ld < LEAD_4) ? 2 : 3);
			k = $urandom_range(0, need - 1);
			add(ld);
			for (int i = 0; i < k; i++)
				add(i == 0 ? second_for(ld) : any_cont());
		end else if (pick < 98) begin
			// second byte just outside the allowed range
			case ($urandom_range(0, 3))
				0: begin add(LEAD_3); add(8'($urandom_range(8'h80, 8'h9F))); end
				1: begin add(LEAD_ED); add(8'($urandom_range(8'hA0, 8'hBF))); end
				2: begin add(LEAD_4); add(8'($urandom_range(8'h80, 8'h8F))); end
				default: begin add(LEAD_MAX); add(8'($urandom_range(8'h90, 8'hBF))); end
			endcase
		end else begin
			add(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic send(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// request and result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// receiver: stall pattern changes every span, one long hold-off mid run
	initial begin
		int unsigned mode, span;
		bit held_off;
		logic rdy;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_off && items_sent >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			for (int c = 0; c < span; c++) begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = (c % 4) != 3;
					2: rdy = 1'($urandom_range(0, 1));
					default: rdy = (c % 3) == 0;
				endcase
				out_ready <= rdy;
				@(posedge clk);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int unsigned directed_items, burst_left, gap;
		sb = new();

		// ascii extremes, stray continuations, invalid leads
		add(8'h00); add(8'h7F); add(8'h80); add(8'hBF);
		add(8'hC0); add(8'hF5); add(8'hFF);
		// valid sequences at the range edges
		add(8'hC2); add(8'h80);
		add(8'hDF); add(8'hBF);
		add(8'hE0); add(8'hA0); add(8'h80);
		// overlong three-byte form is broken
		add(8'hE0); add(8'h9F);
		add(8'hED); add(8'h9F); add(8'hBF);
		// two held continuations, then an invalid lead breaks them
		add(8'hF0); add(8'h90); add(8'h80); add(8'hF5);
		// truncated at end of blob, flushed
		add(8'hF4); add(8'h8F); mark_end();
		// final byte with no output gives the empty end marker
		add(8'hC1); mark_end();
		directed_items = stim_q.size();

		while (stim_q.size() < directed_items + RANDOM_ITEMS) begin
			repeat ($urandom_range(1, 8)) add_char();
			mark_end();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = 0;
		foreach (stim_q[i]) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 7) == 0) begin
					burst_left = $urandom_range(30, 60);
					gap = 0;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap = $urandom_range(0, 6);
				end
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send(stim_q[i]);
			burst_left--;
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input bytes in %0d blobs, %0d output results checked",
			sb.requests, sb.blobs, sb.results);
		$display("including %0d latin-1 repairs, %0d empty end markers, %0d mismatches",
			sb.repairs, sb.markers, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
